>>> src/picture_property_tween_macros.svh
// Assertion macros for the sprite property tween.
// The checks are compiled out when SYNTHESIS is defined.
`ifndef PICTURE_PROPERTY_TWEEN_MACROS_SVH
`define PICTURE_PROPERTY_TWEEN_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define PPT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define PPT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PPT_ASSERT_IMP(label, ante, cons, msg)
`define PPT_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> src/ppt_pkg.sv
package ppt_pkg;

	// Number of animated properties and the width of a channel index.
	localparam int NCHAN = 9;
	localparam int CH_W = 4;

	// Integer width of a target; every property fits in 12 signed bits.
	localparam int TGT_W = 12;

	// Frames-left counter.
	localparam int FRAMES_W = 13;
	localparam logic [FRAMES_W-1:0] FRAMES_MAX = 13'd8191;

	// Channel order in the memories.
	localparam logic [CH_W-1:0] CH_X = 4'd0;
	localparam logic [CH_W-1:0] CH_Y = 4'd1;
	localparam logic [CH_W-1:0] CH_RED = 4'd2;
	localparam logic [CH_W-1:0] CH_GREEN = 4'd3;
	localparam logic [CH_W-1:0] CH_BLUE = 4'd4;
	localparam logic [CH_W-1:0] CH_SAT = 4'd5;
	localparam logic [CH_W-1:0] CH_MAG = 4'd6;
	localparam logic [CH_W-1:0] CH_TOP = 4'd7;
	localparam logic [CH_W-1:0] CH_BOT = 4'd8;

	typedef enum logic [2:0] {
		ACT_TICK = 3'd0,
		ACT_TRANSITION = 3'd1,
		ACT_ROTATE = 3'd2,
		ACT_WAVER = 3'd3,
		ACT_STOP = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		SPIN_NONE = 2'd0,
		SPIN_ROTATE = 2'd1,
		SPIN_WAVER = 2'd2
	} spin_mode_t;

	// Integer value of a channel after reset: full colors, 100 percent size.
	function automatic logic signed [TGT_W-1:0] chan_reset(input logic [CH_W-1:0] ch);
		logic signed [TGT_W-1:0] v;
		case (ch) inside
			CH_RED, CH_GREEN, CH_BLUE, CH_SAT: v = 12'sd255;
			CH_MAG: v = 12'sd100;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> src/ppt_ram.sv
module ppt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/picture_property_tween.sv
// Sprite property tween.
// Requests arrive on the item channel (item_valid, item_stall) and carry an
// action with its arguments; every request yields exactly one result on the
// result channel (result_valid, result_stall) that shows the nine integer
// property values, the spin angle and the transition busy flag after the
// request has been applied.
// A tick with no transition running and the rotate, waver, stop and unknown
// actions go straight to the finish state; a begin transition first writes
// the properties to memory one after the other; and a tick that advances a
// transition runs the shared divider, which retires four quotient bits per
// cycle and serves the nine properties one after the other.
// One request is worked on at a time; the next one may be accepted while the
// previous result still waits on a stalled receiver, but its own result is
// held back until the output register is free.
// Reset clears all control state at once: properties read as their default
// values (origin, full colors, 100 percent size) until first written, with no
// clearing pass over the memories.
module picture_property_tween #(
	parameter int FRAME_RATE = 60,
	parameter int FRACTION_BITS = 8
) (
	input logic clk,
	input logic arst_n,

	input logic item_valid,
	output logic item_stall,
	input logic [2:0] action,
	input logic [9:0] transition_tenths,
	input logic signed [11:0] target_x,
	input logic signed [11:0] target_y,
	input logic [7:0] target_red,
	input logic [7:0] target_green,
	input logic [7:0] target_blue,
	input logic [7:0] target_saturation,
	input logic [9:0] target_magnify,
	input logic [6:0] target_top_alpha,
	input logic [6:0] target_bottom_alpha,
	input logic [7:0] spin_speed,

	output logic result_valid,
	input logic result_stall,
	output logic signed [11:0] cur_x,
	output logic signed [11:0] cur_y,
	output logic [7:0] cur_red,
	output logic [7:0] cur_green,
	output logic [7:0] cur_blue,
	output logic [7:0] cur_saturation,
	output logic [9:0] cur_magnify,
	output logic [6:0] cur_top_alpha,
	output logic [6:0] cur_bottom_alpha,
	output logic [31:0] spin_angle,
	output logic transition_busy
);

	import ppt_pkg::*;

`include "picture_property_tween_macros.svh"

	// Current values are fixed point with FRACTION_BITS fraction bits.
	localparam int CW = TGT_W + FRACTION_BITS;
	// The interpolation numerator: cur * (k - 1) plus the shifted target.
	localparam int PW = CW + FRAMES_W + 2;
	// The divider retires RB quotient bits per cycle.
	localparam int RB = 4;
	localparam int DIV_ITER = (CW + RB - 1) / RB;
	localparam int QP = DIV_ITER * RB;
	localparam int DCW = $clog2(DIV_ITER);

	// Frames = tenths * FRAME_RATE / 10, done as one multiply by a scaled
	// reciprocal of ten. The error of the reciprocal stays below one part in
	// the product range, so the floor is exact for all ten-bit tenths.
	localparam int DIV_SH = 22;
	localparam int RECIP10 = (1 << DIV_SH) / 10 + 1;
	localparam logic [27:0] FR_MUL = 28'(FRAME_RATE * RECIP10);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_MUL,
		S_SUM,
		S_DIV,
		S_WB,
		S_FIN
	} state_t;

	state_t state_q;
	logic [CH_W-1:0] ch_q;
	logic [DCW-1:0] div_cnt_q;
	logic tween_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [31:0] spin_acc_q;
	logic [7:0] spin_step_q;
	spin_mode_t spin_mode_q;
	logic [NCHAN-1:0] cur_vld_q;
	logic [NCHAN-1:0] tgt_vld_q;
	logic signed [TGT_W-1:0] int_q [NCHAN];

	logic result_valid_q;
	logic signed [TGT_W-1:0] res_int_q [NCHAN];
	logic [31:0] res_angle_q;
	logic res_busy_q;

	// Datapath registers.
	logic signed [TGT_W-1:0] tgt_in_q [NCHAN];
	logic snap_q;
	logic signed [PW-2:0] prod_s1;
	logic signed [TGT_W-1:0] tgt_s1;
	logic [FRAMES_W-1:0] rem_q;
	logic [QP-1:0] dlo_q;
	logic [QP-1:0] quo_q;
	logic neg_q;

	// Memory ports.
	logic cur_we;
	logic [CW-1:0] cur_wdata;
	logic [CW-1:0] cur_rdata;
	logic tgt_we;
	logic [TGT_W-1:0] tgt_rdata;
	logic rd_en;
	logic [CH_W-1:0] raddr;

	logic accept;
	logic start_tween;
	logic [37:0] fr_prod;
	logic [FRAMES_W-1:0] frames_new;
	logic [FRAMES_W-1:0] km1;
	logic signed [CW-1:0] cur_rd;
	logic signed [TGT_W-1:0] tgt_rd;
	logic signed [PW-1:0] num;
	logic [PW-1:0] mag;
	logic [FRAMES_W-1:0] rem_nxt;
	logic [QP-1:0] dlo_nxt;
	logic [QP-1:0] quo_nxt;
	logic [CW-1:0] qmag;
	logic signed [CW-1:0] cur_new;
	logic [FRAMES_W-1:0] frames_fin;

	// The block takes a request only when the previous one is finished.
	assign item_stall = (state_q != S_IDLE);
	assign accept = item_valid && !item_stall;
	assign start_tween = accept && (action == ACT_TICK) && (frames_q != '0);

	// Transition length in frames, saturated to the counter.
	always_comb begin
		fr_prod = 38'(transition_tenths) * FR_MUL;
		if (fr_prod[37:DIV_SH] > 16'(FRAMES_MAX)) begin
			frames_new = FRAMES_MAX;
		end else begin
			frames_new = fr_prod[DIV_SH+FRAMES_W-1:DIV_SH];
		end
	end

	// A tick that advances a transition reads channel zero as it is accepted;
	// each write-back reads the next channel so the multiplier starts at once.
	assign rd_en = start_tween || (state_q == S_WB && ch_q != CH_W'(NCHAN - 1));
	assign raddr = (state_q == S_WB) ? CH_W'(ch_q + 1'b1) : '0;

	assign tgt_we = (state_q == S_LOAD);
	assign cur_we = (state_q == S_WB) || (state_q == S_LOAD && snap_q);
	assign cur_wdata = (state_q == S_WB) ? cur_new
		: CW'(CW'(tgt_in_q[ch_q]) <<< FRACTION_BITS);

	ppt_ram #(
		.WIDTH(CW),
		.DEPTH(NCHAN)
	) u_cur_ram (
		.clk(clk),
		.we(cur_we),
		.waddr(ch_q),
		.wdata(cur_wdata),
		.re(rd_en),
		.raddr(raddr),
		.rdata(cur_rdata)
	);

	ppt_ram #(
		.WIDTH(TGT_W),
		.DEPTH(NCHAN)
	) u_tgt_ram (
		.clk(clk),
		.we(tgt_we),
		.waddr(ch_q),
		.wdata(tgt_in_q[ch_q]),
		.re(rd_en),
		.raddr(raddr),
		.rdata(tgt_rdata)
	);

	// An entry that was never written reads as its reset value.
	assign cur_rd = cur_vld_q[ch_q] ? cur_rdata
		: CW'(CW'(chan_reset(ch_q)) <<< FRACTION_BITS);
	assign tgt_rd = tgt_vld_q[ch_q] ? tgt_rdata : chan_reset(ch_q);
	assign km1 = frames_q - 1'b1;

	// Numerator of the interpolation and its magnitude for the divider.
	always_comb begin
		num = PW'(prod_s1) + (PW'(tgt_s1) <<< FRACTION_BITS);
		mag = num[PW-1] ? (~num + 1'b1) : num;
	end

	// Restoring division by k, RB quotient bits per cycle. The remainder
	// always stays below k, so it fits the counter width.
	always_comb begin
		logic [FRAMES_W:0] t;
		rem_nxt = rem_q;
		dlo_nxt = dlo_q;
		quo_nxt = quo_q;
		for (int j = 0; j < RB; j++) begin
			t = {rem_nxt, dlo_nxt[QP-1]};
			dlo_nxt = {dlo_nxt[QP-2:0], 1'b0};
			if (t >= {1'b0, frames_q}) begin
				rem_nxt = FRAMES_W'(t - {1'b0, frames_q});
				quo_nxt = {quo_nxt[QP-2:0], 1'b1};
			end else begin
				rem_nxt = t[FRAMES_W-1:0];
				quo_nxt = {quo_nxt[QP-2:0], 1'b0};
			end
		end
	end

	// The quotient is truncated toward zero, so the sign goes back on last.
	assign qmag = quo_q[CW-1:0];
	assign cur_new = neg_q ? (~qmag + 1'b1) : qmag;

	assign frames_fin = tween_q ? (frames_q - 1'b1) : frames_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_in_q[CH_X] <= target_x;
			tgt_in_q[CH_Y] <= target_y;
			tgt_in_q[CH_RED] <= TGT_W'(target_red);
			tgt_in_q[CH_GREEN] <= TGT_W'(target_green);
			tgt_in_q[CH_BLUE] <= TGT_W'(target_blue);
			tgt_in_q[CH_SAT] <= TGT_W'(target_saturation);
			tgt_in_q[CH_MAG] <= TGT_W'(target_magnify);
			tgt_in_q[CH_TOP] <= TGT_W'(target_top_alpha);
			tgt_in_q[CH_BOT] <= TGT_W'(target_bottom_alpha);
			snap_q <= (transition_tenths == '0);
		end
		if (state_q == S_MUL) begin
			prod_s1 <= cur_rd * $signed({1'b0, km1});
			tgt_s1 <= tgt_rd;
		end
		if (state_q == S_SUM) begin
			rem_q <= FRAMES_W'(mag >> QP);
			dlo_q <= mag[QP-1:0];
			quo_q <= '0;
			neg_q <= num[PW-1];
		end
		if (state_q == S_DIV) begin
			rem_q <= rem_nxt;
			dlo_q <= dlo_nxt;
			quo_q <= quo_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q <= '0;
			div_cnt_q <= '0;
			tween_q <= 1'b0;
			frames_q <= '0;
			spin_acc_q <= '0;
			spin_step_q <= '0;
			spin_mode_q <= SPIN_NONE;
			cur_vld_q <= '0;
			tgt_vld_q <= '0;
			result_valid_q <= 1'b0;
			res_angle_q <= '0;
			res_busy_q <= 1'b0;
			for (int i = 0; i < NCHAN; i++) begin
				int_q[i] <= chan_reset(CH_W'(i));
				res_int_q[i] <= chan_reset(CH_W'(i));
			end
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q <= '0;
						tween_q <= 1'b0;
						state_q <= S_FIN;
						case (action)
							ACT_TICK: begin
								if (spin_mode_q != SPIN_NONE) begin
									spin_acc_q <= spin_acc_q + 32'(spin_step_q);
								end
								if (frames_q != '0) begin
									tween_q <= 1'b1;
									state_q <= S_MUL;
								end
							end
							ACT_TRANSITION: begin
								frames_q <= frames_new;
								state_q <= S_LOAD;
							end
							ACT_ROTATE: begin
								spin_mode_q <= SPIN_ROTATE;
								spin_step_q <= spin_speed;
								spin_acc_q <= '0;
							end
							ACT_WAVER: begin
								spin_mode_q <= SPIN_WAVER;
								spin_step_q <= spin_speed;
								spin_acc_q <= '0;
							end
							ACT_STOP: begin
								spin_mode_q <= SPIN_NONE;
							end
							default: begin
							end
						endcase
					end
				end
				S_LOAD: begin
					// One channel per cycle; a zero-length transition also
					// snaps the current value to its target.
					tgt_vld_q[ch_q] <= 1'b1;
					if (snap_q) begin
						cur_vld_q[ch_q] <= 1'b1;
						int_q[ch_q] <= tgt_in_q[ch_q];
					end
					if (ch_q == CH_W'(NCHAN - 1)) begin
						state_q <= S_FIN;
					end else begin
						ch_q <= CH_W'(ch_q + 1'b1);
					end
				end
				S_MUL: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					div_cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= DCW'(div_cnt_q + 1'b1);
					if (div_cnt_q == DCW'(DIV_ITER - 1)) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					cur_vld_q[ch_q] <= 1'b1;
					int_q[ch_q] <= TGT_W'(cur_new >>> FRACTION_BITS);
					if (ch_q == CH_W'(NCHAN - 1)) begin
						state_q <= S_FIN;
					end else begin
						ch_q <= CH_W'(ch_q + 1'b1);
						state_q <= S_MUL;
					end
				end
				S_FIN: begin
					// Wait here while the previous result is still stalled.
					if (!result_valid_q || !result_stall) begin
						frames_q <= frames_fin;
						tween_q <= 1'b0;
						result_valid_q <= 1'b1;
						res_int_q <= int_q;
						res_angle_q <= spin_acc_q;
						res_busy_q <= (frames_fin != '0);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign cur_x = res_int_q[CH_X];
	assign cur_y = res_int_q[CH_Y];
	assign cur_red = res_int_q[CH_RED][7:0];
	assign cur_green = res_int_q[CH_GREEN][7:0];
	assign cur_blue = res_int_q[CH_BLUE][7:0];
	assign cur_saturation = res_int_q[CH_SAT][7:0];
	assign cur_magnify = res_int_q[CH_MAG][9:0];
	assign cur_top_alpha = res_int_q[CH_TOP][6:0];
	assign cur_bottom_alpha = res_int_q[CH_BOT][6:0];
	assign spin_angle = res_angle_q;
	assign transition_busy = res_busy_q;

	`PPT_ASSERT_IMP(a_rem_below_divisor, state_q == S_DIV, rem_q < frames_q, "divider remainder reached the divisor")
	`PPT_ASSERT_IMP(a_tween_has_frames, tween_q, frames_q != '0, "tween running with no frames left")
	`PPT_ASSERT_NXT(a_wb_marks_valid, state_q == S_WB, cur_vld_q[$past(ch_q)], "written entry not marked valid")
	`PPT_ASSERT_IMP(a_result_from_fin, $rose(result_valid), $past(state_q == S_FIN), "result raised outside finish")

endmodule
